/* sv/poi_pkg.sv */
// Package for the planar odometry integrator.
// Holds widths, constants, the arctangent table and shared functions.
// No dependencies.
package poi_pkg;

	localparam int CORDIC_STEPS   = 16;
	localparam int TRIG_FRAC_BITS = 14;

	localparam int N_ITER = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int IW     = $clog2(N_ITER);
	localparam int CW     = 34;
	localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);

	localparam int TRW  = TRIG_FRAC_BITS + 2;
	localparam int PW   = 16 + TRW;
	localparam int RXW  = PW + 1;
	localparam int DTW  = 21;
	localparam int NW   = RXW + DTW;
	localparam int MW   = NW + 1;
	localparam int QW   = MW + 1;
	localparam int DW   = 16 + TRIG_FRAC_BITS;
	localparam int WDW  = 37;
	localparam int MA_W = (RXW > WDW) ? RXW : WDW;
	localparam int MB_W = 23;
	localparam int MP_W = MA_W + MB_W;

	localparam logic [DW-1:0] DIV_C = DW'(62500) << TRIG_FRAC_BITS;
	localparam logic signed [MB_W-1:0] ANG_SCALE = MB_W'(2799883);

	// time scale split as 15625 * 2^(TRIG_FRAC_BITS + 2)
	localparam int DIV_SH  = TRIG_FRAC_BITS + 2;
	localparam int DIV_ODD = 15625;
	localparam int DAW     = 35;
	localparam int DPRE_SH = 8;
	localparam int DAHW    = DAW - DPRE_SH;
	localparam int RCPW    = 19;
	localparam logic [RCPW-1:0] DIV_RCP = RCPW'(274878);
	localparam int RCP_SH  = 24;
	localparam int DRPW    = DAHW + RCPW;
	localparam int DQW     = DRPW - RCP_SH;
	localparam int DRW     = DAW + 2;

	typedef enum logic [3:0] {
		OP_VXCT = 4'd0,
		OP_VYST = 4'd1,
		OP_VXST = 4'd2,
		OP_VYCT = 4'd3,
		OP_RXDT = 4'd4,
		OP_RYDT = 4'd5,
		OP_WDT  = 4'd6,
		OP_WANG = 4'd7,
		OP_HEAD = 4'd8
	} mul_op_t;

	typedef struct packed {
		logic    load_in;
		logic    cord_start;
		logic    cord_half;
		logic    trig_cap;
		logic    mul_en;
		mul_op_t mul_op;
		logic    pos_upd;
		logic    out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cord_busy;
		logic div_busy;
	} dp_status_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// round Q30 to frac fraction bits, clamp to +-1.0
	function automatic logic signed [31:0] q30_to(input logic signed [CW-1:0] v,
			input int frac);
		logic signed [CW:0] half;
		logic signed [CW:0] one;
		logic signed [CW:0] r;
		half = (CW+1)'(1) << (29 - frac);
		one  = (CW+1)'(1) << frac;
		r    = ((CW+1)'(v) + half) >>> (30 - frac);
		if (r > one)
			r = one;
		else if (r < -one)
			r = -one;
		return 32'(r);
	endfunction

endpackage

/* sv/poi_cordic.sv */
// Iterative rotation-mode CORDIC giving Q30 cosine and sine of a binary angle.
// One micro-rotation per cycle. Depends on poi_pkg.
module poi_cordic (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [31:0]                     ang,
	output logic                            busy,
	output logic signed [poi_pkg::CW-1:0]   cos_v,
	output logic signed [poi_pkg::CW-1:0]   sin_v
);

	logic signed [poi_pkg::CW-1:0] x_q, y_q, z_q;
	logic [poi_pkg::IW-1:0]        i_q;
	logic                          neg_q, busy_q;
	logic [31:0]                   fold_sum, ang_f;
	logic signed [poi_pkg::CW-1:0] atan_v;

	always_comb begin
		fold_sum = ang + 32'h4000_0000;
		ang_f    = fold_sum[31] ? ang + 32'h8000_0000 : ang;
		atan_v   = poi_pkg::CW'(poi_pkg::atan_entry(5'(i_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			if (i_q == poi_pkg::IW'(poi_pkg::N_ITER - 1))
				busy_q <= 1'b0;
			else
				i_q <= i_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= fold_sum[31];
			x_q   <= poi_pkg::GAIN_Q30;
			y_q   <= '0;
			z_q   <= poi_pkg::CW'($signed(ang_f));
		end else if (busy_q) begin
			if (!z_q[poi_pkg::CW-1]) begin
				x_q <= x_q - (y_q >>> i_q);
				y_q <= y_q + (x_q >>> i_q);
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + (y_q >>> i_q);
				y_q <= y_q - (x_q >>> i_q);
				z_q <= z_q + atan_v;
			end
		end
	end

	assign busy  = busy_q;
	assign cos_v = neg_q ? -x_q : x_q;
	assign sin_v = neg_q ? -y_q : y_q;

endmodule

/* sv/poi_div.sv */
// Divider by the fixed time scale, rounding half away from zero.
// Reciprocal multiply to an estimate, then a one-step correction. Depends on poi_pkg.
module poi_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [poi_pkg::NW-1:0]   num,
	output logic                            busy,
	output logic signed [poi_pkg::QW-1:0]   quo
);

	logic [poi_pkg::DAW-1:0]  a_q;
	logic [poi_pkg::DQW-1:0]  qe_q, q_q;
	logic [poi_pkg::DRW-1:0]  qd_q;
	logic                     neg_q;
	logic [2:0]               stage_q;
	logic [poi_pkg::MW-1:0]   mag;
	logic [poi_pkg::DRPW-1:0] est;
	logic [poi_pkg::DRW-1:0]  a_ext, diff;
	logic                     over, under;

	always_comb begin
		mag   = num[poi_pkg::NW-1] ? poi_pkg::MW'(-num) : poi_pkg::MW'(num);
		mag   = mag + poi_pkg::MW'(poi_pkg::DIV_C >> 1);
		est   = poi_pkg::DRPW'(a_q[poi_pkg::DAW-1:poi_pkg::DPRE_SH]) *
			poi_pkg::DRPW'(poi_pkg::DIV_RCP);
		a_ext = poi_pkg::DRW'(a_q);
		over  = qd_q > a_ext;
		diff  = a_ext - qd_q;
		under = diff >= poi_pkg::DRW'(poi_pkg::DIV_ODD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else begin
			stage_q <= {stage_q[1:0], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mag[poi_pkg::DIV_SH +: poi_pkg::DAW];
			neg_q <= num[poi_pkg::NW-1];
		end
		if (stage_q[0])
			qe_q <= est[poi_pkg::DRPW-1:poi_pkg::RCP_SH];
		if (stage_q[1])
			qd_q <= poi_pkg::DRW'(qe_q) * poi_pkg::DRW'(poi_pkg::DIV_ODD);
		if (stage_q[2]) begin
			if (over)
				q_q <= qe_q - 1'b1;
			else if (under)
				q_q <= qe_q + 1'b1;
			else
				q_q <= qe_q;
		end
	end

	assign busy = |stage_q;
	assign quo  = neg_q ? -$signed(poi_pkg::QW'(q_q)) : $signed(poi_pkg::QW'(q_q));

endmodule

/* sv/poi_ctrl.sv */
// Sequencer for the odometry integrator: trig, multiplies, divide, output.
// Drives datapath commands and the channel handshakes. Depends on poi_pkg.
module poi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  poi_pkg::dp_status_t sts,
	output poi_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_TRIG = 6'b000010,
		S_MUL  = 6'b000100,
		S_ROT2 = 6'b001000,
		S_WAIT = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       ov_q;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		cmd.mul_op  = poi_pkg::mul_op_t'(cnt_q);
		in_stall    = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in    = 1'b1;
					cmd.cord_start = 1'b1;
					state_d        = S_TRIG;
				end
			end
			S_TRIG: begin
				if (!sts.cord_busy) begin
					cmd.trig_cap = 1'b1;
					cnt_d        = '0;
					state_d      = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				if (cnt_q == 4'(poi_pkg::OP_HEAD))
					state_d = S_ROT2;
				else
					cnt_d = cnt_q + 4'd1;
			end
			S_ROT2: begin
				cmd.cord_start = 1'b1;
				cmd.cord_half  = 1'b1;
				state_d        = S_WAIT;
			end
			S_WAIT: begin
				cmd.cord_half = 1'b1;
				if (!sts.cord_busy && !sts.div_busy) begin
					cmd.pos_upd = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				cmd.cord_half = 1'b1;
				if (!ov_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ov_q    <= cmd.out_load | (ov_q & out_stall);
		end
	end

	assign out_valid = ov_q;

endmodule

/* sv/poi_dp.sv */
// Datapath: pose accumulators, shared multiplier, CORDIC and two dividers.
// Steered by poi_ctrl commands. Depends on poi_pkg, poi_cordic, poi_div.
module poi_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  poi_pkg::ctrl_cmd_t  cmd,
	output poi_pkg::dp_status_t sts,
	input  logic [19:0]         dt_us,
	input  logic signed [15:0]  lin_vel_x,
	input  logic signed [15:0]  lin_vel_y,
	input  logic signed [15:0]  ang_vel_z,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic [31:0]         heading_angle,
	output logic signed [15:0]  quat_z,
	output logic signed [15:0]  quat_w
);

	localparam int SW = poi_pkg::QW + 1;

	logic [19:0]                        dt_q;
	logic signed [15:0]                 vx_q, vy_q, wz_q;
	logic signed [poi_pkg::TRW-1:0]     ct_q, st_q;
	logic signed [poi_pkg::PW-1:0]      t0_q, t1_q;
	logic signed [poi_pkg::RXW-1:0]     rx_q, ry_q;
	logic signed [poi_pkg::NW-1:0]      nx_q, ny_q;
	logic signed [poi_pkg::WDW-1:0]     wd_q;
	logic signed [poi_pkg::MP_W-1:0]    dh_q, hsum;
	logic signed [31:0]                 x_q, y_q;
	logic [31:0]                        head_q;
	logic signed [poi_pkg::MA_W-1:0]    op_a;
	logic signed [poi_pkg::MB_W-1:0]    op_b, dt_s;
	logic signed [poi_pkg::MP_W-1:0]    prod;
	logic [31:0]                        cord_ang;
	logic signed [poi_pkg::CW-1:0]      cos_v, sin_v;
	logic                               cord_busy, dx_busy, dy_busy, div_start;
	logic signed [poi_pkg::QW-1:0]      qx, qy;

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [poi_pkg::QW-1:0] d);
		logic signed [SW-1:0] s;
		s = SW'(a) + SW'(d);
		if (s > SW'(32'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		else if (s < SW'(32'sh8000_0000))
			return 32'sh8000_0000;
		return s[31:0];
	endfunction

	assign cord_ang  = cmd.cord_half ? {1'b0, head_q[31:1]} : head_q;
	assign div_start = cmd.mul_en && (cmd.mul_op == poi_pkg::OP_HEAD);
	assign dt_s      = poi_pkg::MB_W'($signed({1'b0, dt_q}));
	assign hsum      = dh_q + poi_pkg::MP_W'(32'sh0080_0000);

	poi_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cmd.cord_start), .ang(cord_ang),
		.busy(cord_busy), .cos_v(cos_v), .sin_v(sin_v)
	);

	poi_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(nx_q),
		.busy(dx_busy), .quo(qx)
	);

	poi_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(ny_q),
		.busy(dy_busy), .quo(qy)
	);

	assign sts.cord_busy = cord_busy;
	assign sts.div_busy  = dx_busy | dy_busy;

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.mul_op)
			poi_pkg::OP_VXCT: begin
				op_a = poi_pkg::MA_W'(vx_q);
				op_b = poi_pkg::MB_W'(ct_q);
			end
			poi_pkg::OP_VYST: begin
				op_a = poi_pkg::MA_W'(vy_q);
				op_b = poi_pkg::MB_W'(st_q);
			end
			poi_pkg::OP_VXST: begin
				op_a = poi_pkg::MA_W'(vx_q);
				op_b = poi_pkg::MB_W'(st_q);
			end
			poi_pkg::OP_VYCT: begin
				op_a = poi_pkg::MA_W'(vy_q);
				op_b = poi_pkg::MB_W'(ct_q);
			end
			poi_pkg::OP_RXDT: begin
				op_a = poi_pkg::MA_W'(rx_q);
				op_b = dt_s;
			end
			poi_pkg::OP_RYDT: begin
				op_a = poi_pkg::MA_W'(ry_q);
				op_b = dt_s;
			end
			poi_pkg::OP_WDT: begin
				op_a = poi_pkg::MA_W'(wz_q);
				op_b = dt_s;
			end
			poi_pkg::OP_WANG: begin
				op_a = poi_pkg::MA_W'(wd_q);
				op_b = poi_pkg::ANG_SCALE;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		prod = poi_pkg::MP_W'(op_a) * poi_pkg::MP_W'(op_b);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			dt_q <= dt_us;
			vx_q <= lin_vel_x;
			vy_q <= lin_vel_y;
			wz_q <= ang_vel_z;
		end
		if (cmd.trig_cap) begin
			ct_q <= poi_pkg::TRW'(poi_pkg::q30_to(cos_v, poi_pkg::TRIG_FRAC_BITS));
			st_q <= poi_pkg::TRW'(poi_pkg::q30_to(sin_v, poi_pkg::TRIG_FRAC_BITS));
		end
		if (cmd.mul_en) begin
			case (cmd.mul_op)
				poi_pkg::OP_VXCT: t0_q <= poi_pkg::PW'(prod);
				poi_pkg::OP_VYST: t1_q <= poi_pkg::PW'(prod);
				poi_pkg::OP_VXST: begin
					rx_q <= poi_pkg::RXW'(t0_q) - poi_pkg::RXW'(t1_q);
					t0_q <= poi_pkg::PW'(prod);
				end
				poi_pkg::OP_VYCT: t1_q <= poi_pkg::PW'(prod);
				poi_pkg::OP_RXDT: begin
					ry_q <= poi_pkg::RXW'(t0_q) + poi_pkg::RXW'(t1_q);
					nx_q <= poi_pkg::NW'(prod);
				end
				poi_pkg::OP_RYDT: ny_q <= poi_pkg::NW'(prod);
				poi_pkg::OP_WDT:  wd_q <= poi_pkg::WDW'(prod);
				poi_pkg::OP_WANG: dh_q <= prod;
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			pos_x         <= x_q;
			pos_y         <= y_q;
			heading_angle <= head_q;
			quat_z        <= 16'(poi_pkg::q30_to(sin_v, 14));
			quat_w        <= 16'(poi_pkg::q30_to(cos_v, 14));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			head_q <= '0;
		end else begin
			if (div_start)
				head_q <= head_q + hsum[55:24];
			if (cmd.pos_upd) begin
				x_q <= sat_add(x_q, qx);
				y_q <= sat_add(y_q, qy);
			end
		end
	end

endmodule

/* sv/planar_odometry_integrator_top.sv */
// Planar dead-reckoning odometry integrator, top level.
// Depends on poi_pkg, poi_ctrl, poi_dp.
//
// One odometry update is accepted at a time and gives one pose beat. An update
// runs as a CORDIC pass on the old heading, nine steps of the shared multiplier,
// then the CORDIC pass for the quaternion with the position dividers hidden
// under it. The result sits in an output register; the next update is taken
// once that beat has been loaded, so a stalled output holds the block after
// one more update. The CORDIC step count is capped at 24.
module planar_odometry_integrator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [19:0]        dt_us,
	input  logic signed [15:0] lin_vel_x,
	input  logic signed [15:0] lin_vel_y,
	input  logic signed [15:0] ang_vel_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [31:0]        heading_angle,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);

	poi_pkg::ctrl_cmd_t  cmd;
	poi_pkg::dp_status_t sts;

	poi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	poi_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.dt_us(dt_us), .lin_vel_x(lin_vel_x), .lin_vel_y(lin_vel_y),
		.ang_vel_z(ang_vel_z), .pos_x(pos_x), .pos_y(pos_y),
		.heading_angle(heading_angle), .quat_z(quat_z), .quat_w(quat_w)
	);

endmodule
